// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bsg_pkg.sv =====
// ----------------------------------------------------------------------------
// bsg_pkg
// Types and constants shared by the bitmap-to-grayscale stream blocks.
// ----------------------------------------------------------------------------
package bsg_pkg;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] OS2_HDR_SIZE  = 32'd12;
  localparam logic [31:0] WIN_HDR_MIN   = 32'd40;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_BMP    = 3'd1;
  localparam logic [2:0] ST_UNSUPPORT  = 3'd2;
  localparam logic [2:0] ST_BAD_HDR    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd4;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd5;

  localparam logic [5:0] BPP1  = 6'd1;
  localparam logic [5:0] BPP4  = 6'd4;
  localparam logic [5:0] BPP8  = 6'd8;
  localparam logic [5:0] BPP24 = 6'd24;
  localparam logic [5:0] BPP32 = 6'd32;

  localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WEIGHTED   = 2'd2;

  localparam logic [7:0]  W_RED = 8'd30;
  localparam logic [7:0]  W_GRN = 8'd59;
  localparam logic [7:0]  W_BLU = 8'd11;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SHIFT_100 = 19;
  localparam logic [9:0]  RECIP_3   = 10'd683;
  localparam int          SHIFT_3   = 11;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        kind;
    logic        use_pal;
    logic        black;
    logic [7:0]  idx;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  status;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  gray;
    logic [15:0] row;
    logic [15:0] col;
    logic [2:0]  status;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [23:0] data;
  } pal_wr_t;

  function automatic logic is_supported(input logic [15:0] b);
    return (b == 16'd1) || (b == 16'd4) || (b == 16'd8) || (b == 16'd24) ||
           (b == 16'd32);
  endfunction

  function automatic logic [8:0] default_colors(input logic [5:0] bpp);
    logic [8:0] n;
    n = 9'd0;
    if (bpp == BPP8) n = 9'd256;
    else if (bpp == BPP4) n = 9'd16;
    else if (bpp == BPP1) n = 9'd2;
    return n;
  endfunction

endpackage

// ===== sv/bsg_palette_ram.sv =====
// ----------------------------------------------------------------------------
// bsg_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsg_palette_ram
  import bsg_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  pal_wr_t     wr,
  input  logic        rd_en,
  input  logic [7:0]  rd_addr,
  output logic [23:0] rd_data
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] mem [PALETTE_DEPTH];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[PAL_AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[PAL_AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/bsg_parser.sv =====
// ----------------------------------------------------------------------------
// bsg_parser
// Byte parser: headers, palette load, offset skip and pixel sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsg_parser
  import bsg_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int DIM_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  input  logic        in_start,
  input  logic        credit_ok,
  input  logic [15:0] max_width,
  input  logic [15:0] max_height,
  output logic        burst,
  output logic        req_v,
  output req_t        req,
  output pal_wr_t     pal_wr,
  output logic        pal_rd_en,
  output logic [7:0]  pal_rd_addr
);

  typedef enum logic [1:0] {PH_HEADER, PH_PRE, PH_PIXELS, PH_DONE} phase_t;

  localparam logic [15:0] DIM_CAP = 16'((32'd1 << DIM_BITS) - 32'd1);
  localparam logic [8:0]  PAL_DEPTH9 = 9'(PALETTE_DEPTH);

  phase_t      phase_r, phase_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [31:0] fa_r, fa_nxt;
  logic [31:0] doff_r, doff_nxt;
  logic [31:0] hsize_r, hsize_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        topdown_r, topdown_nxt;
  logic [5:0]  bpp_r, bpp_nxt;
  logic [8:0]  palcnt_r, palcnt_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [1:0]  ch_r, ch_nxt;
  logic [23:0] part_r, part_nxt;
  logic        burst_r, burst_nxt;
  logic [2:0]  bsub_r, bsub_nxt;
  logic [7:0]  bbyte_r, bbyte_nxt;

  logic [15:0] lim_w, lim_h;
  logic        start;
  logic [31:0] p, fa_new, clr_cnt, mag;
  logic [15:0] hi;
  logic        do_fail, do_fin, do_emit, px_pal;
  logic [2:0]  fail_code;
  logic [7:0]  px_idx;
  logic [23:0] px_rgb;
  logic [16:0] col_inc, row_inc;
  logic        px_end, px_fin;
  logic [15:0] px_row;
  logic [1:0]  rb, pad_calc;
  logic [3:0]  w3;
  logic [3:0]  w_half;
  logic [5:0]  w_oct;
  logic [8:0]  cnt;
  logic [34:0] pal_end;
  logic        os2, last_k;

  assign lim_w = (max_width < DIM_CAP) ? max_width : DIM_CAP;
  assign lim_h = (max_height < DIM_CAP) ? max_height : DIM_CAP;
  assign start = in_fire && in_start;

  // pixel position bookkeeping
  assign col_inc = {1'b0, col_r} + 17'd1;
  assign row_inc = {1'b0, row_r} + 17'd1;
  assign px_end  = col_inc >= {1'b0, width_r};
  assign px_fin  = px_end && (row_inc >= {1'b0, height_r});
  assign px_row  = topdown_r ? row_r : (height_r - 16'd1 - row_r);

  assign w3     = 4'(width_r[1:0]) * 4'd3;
  assign w_half = {1'b0, width_r[2:0]} + 4'd1;
  assign w_oct  = {1'b0, width_r[4:0]} + 6'd7;

  always_comb begin
    case (bpp_r)
      BPP32:   rb = 2'd0;
      BPP24:   rb = w3[1:0];
      BPP8:    rb = width_r[1:0];
      BPP4:    rb = w_half[2:1];
      default: rb = w_oct[4:3];
    endcase
  end
  assign pad_calc = 2'(~rb + 2'd1);

  always_comb begin
    phase_nxt   = start ? PH_HEADER : phase_r;
    bpos_nxt    = start ? 32'd0 : bpos_r;
    fa_nxt      = start ? 32'd0 : fa_r;
    doff_nxt    = start ? 32'd0 : doff_r;
    hsize_nxt   = start ? 32'd0 : hsize_r;
    width_nxt   = start ? 16'd0 : width_r;
    height_nxt  = start ? 16'd0 : height_r;
    topdown_nxt = start ? 1'b0 : topdown_r;
    bpp_nxt     = start ? 6'd0 : bpp_r;
    palcnt_nxt  = start ? 9'd0 : palcnt_r;
    row_nxt     = start ? 16'd0 : row_r;
    col_nxt     = start ? 16'd0 : col_r;
    pad_nxt     = start ? 2'd0 : pad_r;
    ch_nxt      = start ? 2'd0 : ch_r;
    part_nxt    = start ? 24'd0 : part_r;
    burst_nxt   = burst_r;
    bsub_nxt    = bsub_r;
    bbyte_nxt   = bbyte_r;

    p         = bpos_nxt;
    fa_new    = {in_byte, fa_nxt[31:8]};
    hi        = fa_new[31:16];
    mag       = fa_new;
    clr_cnt   = 32'd0;
    cnt       = 9'd0;
    pal_end   = 35'd0;
    os2       = (hsize_r == OS2_HDR_SIZE);
    last_k    = 1'b0;
    do_fail   = 1'b0;
    do_fin    = 1'b0;
    fail_code = ST_OK;
    do_emit   = 1'b0;
    px_pal    = 1'b0;
    px_idx    = 8'd0;
    px_rgb    = 24'd0;

    req_v  = 1'b0;
    req    = '0;
    pal_wr = '0;

    if (burst_r) begin
      if (credit_ok) begin
        do_emit = 1'b1;
        px_pal  = 1'b1;
        if (bpp_r == BPP4) begin
          px_idx = bsub_r[0] ? {4'd0, bbyte_r[3:0]} : {4'd0, bbyte_r[7:4]};
          last_k = (bsub_r == 3'd1);
        end else begin
          px_idx = {7'd0, bbyte_r[3'd7 - bsub_r]};
          last_k = (bsub_r == 3'd7);
        end
        if (px_end || last_k) burst_nxt = 1'b0;
        else bsub_nxt = bsub_r + 3'd1;
      end
    end else if (in_fire) begin
      unique case (phase_nxt)
        PH_HEADER: begin
          fa_nxt   = fa_new;
          bpos_nxt = p + 32'd1;
          if (p == 32'd1 && hi != BMP_SIGNATURE) begin
            do_fail = 1'b1; fail_code = ST_NOT_BMP;
          end else begin
            if (p == 32'd13) doff_nxt = fa_new;
            if (p == 32'd17) begin
              hsize_nxt = fa_new;
              if (fa_new < WIN_HDR_MIN && fa_new != OS2_HDR_SIZE) begin
                do_fail = 1'b1; fail_code = ST_BAD_HDR;
              end
            end else if (p > 32'd17) begin
              if (os2) begin
                if (p == 32'd19) begin
                  width_nxt = hi;
                  if (hi > lim_w) begin do_fail = 1'b1; fail_code = ST_TOO_LARGE; end
                end else if (p == 32'd21) begin
                  height_nxt = hi;
                  if (hi > lim_h) begin do_fail = 1'b1; fail_code = ST_TOO_LARGE; end
                end else if (p == 32'd23) begin
                  if (hi != 16'd1) begin do_fail = 1'b1; fail_code = ST_UNSUPPORT; end
                end else if (p == 32'd25) begin
                  if (!is_supported(hi)) begin
                    do_fail = 1'b1; fail_code = ST_UNSUPPORT;
                  end else begin
                    bpp_nxt = hi[5:0];
                    do_fin  = 1'b1;
                  end
                end
              end else begin
                if (p == 32'd21) begin
                  width_nxt = fa_new[15:0];
                  if (fa_new > {16'd0, lim_w}) begin
                    do_fail = 1'b1; fail_code = ST_TOO_LARGE;
                  end
                end else if (p == 32'd25) begin
                  if (fa_new[31]) begin
                    mag = 32'd0 - fa_new;
                    topdown_nxt = 1'b1;
                  end
                  height_nxt = mag[15:0];
                  if (mag > {16'd0, lim_h}) begin
                    do_fail = 1'b1; fail_code = ST_TOO_LARGE;
                  end
                end else if (p == 32'd27) begin
                  if (hi != 16'd1) begin do_fail = 1'b1; fail_code = ST_UNSUPPORT; end
                end else if (p == 32'd29) begin
                  if (!is_supported(hi)) begin
                    do_fail = 1'b1; fail_code = ST_UNSUPPORT;
                  end else begin
                    bpp_nxt = hi[5:0];
                  end
                end else if (p == 32'd49) begin
                  clr_cnt = fa_new;
                  do_fin  = 1'b1;
                end
              end
            end
          end

          if (do_fin) begin
            if (os2 || clr_cnt == 32'd0) clr_cnt = {23'd0, default_colors(bpp_nxt)};
            cnt = (clr_cnt > 32'(PALETTE_DEPTH)) ? PAL_DEPTH9 : clr_cnt[8:0];
            palcnt_nxt = cnt;
            pal_end = 35'd14 + {3'd0, hsize_r} +
                      (os2 ? 35'(cnt) * 35'd3 : {24'd0, cnt, 2'b00});
            if ({3'd0, doff_r} < pal_end) begin
              do_fail = 1'b1; fail_code = ST_BAD_OFFSET;
            end else begin
              req_v      = 1'b1;
              req.kind   = 1'b1;
              req.status = ST_OK;
              req.w      = width_nxt;
              req.h      = height_nxt;
              if (width_nxt == 16'd0 || height_nxt == 16'd0) begin
                req.last  = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                col_nxt  = 16'd0;
                ch_nxt   = 2'd0;
                part_nxt = 24'd0;
                if ({1'b0, doff_r} == {1'b0, p} + 33'd1) begin
                  phase_nxt = PH_PIXELS;
                  row_nxt   = 16'd0;
                  pad_nxt   = 2'd0;
                end else begin
                  phase_nxt = PH_PRE;
                end
              end
            end
          end

          if (do_fail) begin
            req_v      = 1'b1;
            req        = '0;
            req.kind   = 1'b1;
            req.status = fail_code;
            req.w      = width_nxt;
            req.h      = height_nxt;
            req.last   = 1'b1;
            phase_nxt  = PH_DONE;
          end
        end

        PH_PRE: begin
          if ({2'd0, p} >= {2'd0, hsize_r} + 34'd14 && col_r < {7'd0, palcnt_r}) begin
            case (ch_r)
              2'd0: begin part_nxt = {16'd0, in_byte}; ch_nxt = 2'd1; end
              2'd1: begin part_nxt = {8'd0, in_byte, part_r[7:0]}; ch_nxt = 2'd2; end
              2'd2: begin
                if ({1'b0, col_r} < 17'(PALETTE_DEPTH)) begin
                  pal_wr.en   = 1'b1;
                  pal_wr.addr = col_r[7:0];
                  pal_wr.data = {in_byte, part_r[15:0]};
                end
                if (os2) begin col_nxt = col_r + 16'd1; ch_nxt = 2'd0; end
                else ch_nxt = 2'd3;
              end
              default: begin col_nxt = col_r + 16'd1; ch_nxt = 2'd0; end
            endcase
          end
          bpos_nxt = p + 32'd1;
          if (p + 32'd1 == doff_r) begin
            phase_nxt = PH_PIXELS;
            row_nxt   = 16'd0;
            col_nxt   = 16'd0;
            pad_nxt   = 2'd0;
            ch_nxt    = 2'd0;
            part_nxt  = 24'd0;
          end
        end

        PH_PIXELS: begin
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end else begin
            case (bpp_r)
              BPP32, BPP24: begin
                case (ch_r)
                  2'd0: begin part_nxt = {16'd0, in_byte}; ch_nxt = 2'd1; end
                  2'd1: begin part_nxt = {8'd0, in_byte, part_r[7:0]}; ch_nxt = 2'd2; end
                  2'd2: begin
                    if (bpp_r == BPP24) begin
                      ch_nxt  = 2'd0;
                      do_emit = 1'b1;
                      px_rgb  = {in_byte, part_r[15:0]};
                    end else begin
                      part_nxt = {in_byte, part_r[15:0]};
                      ch_nxt   = 2'd3;
                    end
                  end
                  default: begin
                    ch_nxt  = 2'd0;
                    do_emit = 1'b1;
                    px_rgb  = part_r;
                  end
                endcase
              end
              BPP8: begin
                do_emit = 1'b1; px_pal = 1'b1; px_idx = in_byte;
              end
              BPP4: begin
                do_emit = 1'b1; px_pal = 1'b1; px_idx = {4'd0, in_byte[7:4]};
                if (!px_end) begin burst_nxt = 1'b1; bsub_nxt = 3'd1; bbyte_nxt = in_byte; end
              end
              default: begin
                do_emit = 1'b1; px_pal = 1'b1; px_idx = {7'd0, in_byte[7]};
                if (!px_end) begin burst_nxt = 1'b1; bsub_nxt = 3'd1; bbyte_nxt = in_byte; end
              end
            endcase
          end
        end

        PH_DONE: begin
        end
      endcase
    end

    if (do_emit) begin
      req_v       = 1'b1;
      req.kind    = 1'b0;
      req.use_pal = px_pal;
      req.black   = px_pal && ({1'b0, px_idx} >= PAL_DEPTH9);
      req.idx     = px_idx;
      req.red     = px_rgb[23:16];
      req.grn     = px_rgb[15:8];
      req.blu     = px_rgb[7:0];
      req.row     = px_row;
      req.col     = col_r;
      req.last    = px_fin;
      if (px_end) begin
        col_nxt = 16'd0;
        row_nxt = row_inc[15:0];
        if (px_fin) phase_nxt = PH_DONE;
        else pad_nxt = pad_calc;
      end else begin
        col_nxt = col_inc[15:0];
      end
    end
  end

  assign burst       = burst_r;
  assign pal_rd_en   = req_v && req.use_pal && !req.black;
  assign pal_rd_addr = req.idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      bpos_r    <= 32'd0;
      fa_r      <= 32'd0;
      doff_r    <= 32'd0;
      hsize_r   <= 32'd0;
      width_r   <= 16'd0;
      height_r  <= 16'd0;
      topdown_r <= 1'b0;
      bpp_r     <= 6'd0;
      palcnt_r  <= 9'd0;
      row_r     <= 16'd0;
      col_r     <= 16'd0;
      pad_r     <= 2'd0;
      ch_r      <= 2'd0;
      part_r    <= 24'd0;
      burst_r   <= 1'b0;
      bsub_r    <= 3'd0;
    end else begin
      phase_r   <= phase_nxt;
      bpos_r    <= bpos_nxt;
      fa_r      <= fa_nxt;
      doff_r    <= doff_nxt;
      hsize_r   <= hsize_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      topdown_r <= topdown_nxt;
      bpp_r     <= bpp_nxt;
      palcnt_r  <= palcnt_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pad_r     <= pad_nxt;
      ch_r      <= ch_nxt;
      part_r    <= part_nxt;
      burst_r   <= burst_nxt;
      bsub_r    <= bsub_nxt;
    end
    bbyte_r <= bbyte_nxt;
  end

  `ASSERT_IMPLY(a_burst_in_pixels, burst_r, phase_r == PH_PIXELS, "burst outside pixel phase")
  `ASSERT_IMPLY(a_req_has_credit, req_v, credit_ok, "request issued without fifo credit")

endmodule

// ===== sv/bsg_luma.sv =====
// ----------------------------------------------------------------------------
// bsg_luma
// Two-stage grey conversion: request and palette capture, then the sum; reciprocal scaling on the output.
// ----------------------------------------------------------------------------
module bsg_luma
  import bsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        weighted,
  input  logic        req_v,
  input  req_t        req,
  input  logic [23:0] pal_q,
  output logic [1:0]  inflight,
  output logic        push,
  output out_item_t   push_item
);

  req_t        s1_r;
  logic        v1_r;
  out_item_t   s2_r;
  logic [14:0] sum_r;
  logic        v2_r;

  logic [23:0] rgb;
  logic [14:0] sum;
  logic [27:0] prod_w;
  logic [24:0] prod_m;

  always_comb begin
    if (s1_r.use_pal) rgb = s1_r.black ? 24'd0 : pal_q;
    else rgb = {s1_r.red, s1_r.grn, s1_r.blu};
    if (weighted) begin
      sum = 15'(rgb[23:16]) * 15'(W_RED) + 15'(rgb[15:8]) * 15'(W_GRN) +
            15'(rgb[7:0]) * 15'(W_BLU);
    end else begin
      sum = 15'(rgb[23:16]) + 15'(rgb[15:8]) + 15'(rgb[7:0]);
    end
  end

  assign prod_w = 28'(sum_r) * 28'(RECIP_100);
  assign prod_m = 25'(sum_r) * 25'(RECIP_3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req_v;
      v2_r <= v1_r;
    end
    s1_r        <= req;
    sum_r       <= s1_r.kind ? 15'd0 : sum;
    s2_r.kind   <= s1_r.kind;
    s2_r.gray   <= 8'd0;
    s2_r.row    <= s1_r.row;
    s2_r.col    <= s1_r.col;
    s2_r.status <= s1_r.status;
    s2_r.w      <= s1_r.w;
    s2_r.h      <= s1_r.h;
    s2_r.last   <= s1_r.last;
  end

  always_comb begin
    push_item      = s2_r;
    push_item.gray = weighted ? prod_w[SHIFT_100 +: 8] : prod_m[SHIFT_3 +: 8];
  end

  assign push     = v2_r;
  assign inflight = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// ===== sv/bsg_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bsg_out_fifo
// Result queue between the grey pipeline and the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsg_out_fifo
  import bsg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  out_item_t        push_item,
  input  logic             pop,
  output logic             valid,
  output out_item_t        head,
  output logic [FIFO_AW:0] count
);

  out_item_t          buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
    if (push) buf_r[wr_ptr_r] <= push_item;
  end

  assign valid = (cnt_r != '0);
  assign head  = buf_r[rd_ptr_r];
  assign count = cnt_r;

  `ASSERT_IMPLY(a_no_overflow, push, cnt_r != (FIFO_AW+1)'(FIFO_DEPTH), "push into full queue")
  `ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count did not advance")
  `ASSERT_NEXT(a_cnt_down, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "count did not drop")

endmodule

// ===== sv/bmp_stream_to_grayscale.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_to_grayscale
// Parses a BMP byte stream and emits a header status and grey pixels.
// ----------------------------------------------------------------------------
// Input channel: one file byte per transaction in in_tdata; in_tuser marks the
// first byte of a new file and restarts the parser.
// Output channel: one result per transaction. out_tuser is 0 for a pixel and
// 1 for the header status; out_tlast marks the final pixel or a status that ends the file.
// Configuration: cfg_we writes register cfg_addr (0 max width, 1 max height,
// 2 weighted luma) in the same cycle; write only while the block is idle.
// Throughput: one byte per cycle for header, palette, 8, 24 and 32 bit data
// while the queue has credit. A 4 bit or 1 bit byte holds the input while its
// later pixels go out, one per cycle with credit, each one palette memory read.
// A result is written into the output queue after its request and palette data
// and then its sum are registered (the reciprocal scale sits on the queue write
// path), and it can leave on the following edge.
// Reset clears the parser to the file header phase and empties the queue;
// palette contents are kept. When the receiver stalls, an 8-entry queue
// absorbs results in flight and in_tready drops once it has no room left.
// ----------------------------------------------------------------------------
module bmp_stream_to_grayscale
  import bsg_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int DIM_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tuser,   // [0] file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] gray, [23:8] row, [39:24] column, [42:40] status,
  // [58:43] image_width, [74:59] image_height, [79:75] zero
  output logic [79:0] out_tdata,
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_width_r, max_height_r;
  logic        weighted_r;

  logic             burst, credit_ok, in_fire, req_v, pal_rd_en, push, pop;
  req_t             req;
  pal_wr_t          pal_wr;
  logic [7:0]       pal_rd_addr;
  logic [23:0]      pal_q;
  logic [1:0]       inflight;
  out_item_t        push_item, head;
  logic [FIFO_AW:0] fifo_cnt;
  logic [FIFO_AW+1:0] occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r  <= 16'hFFFF;
      max_height_r <= 16'hFFFF;
      weighted_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_WIDTH:  max_width_r  <= cfg_wdata;
        CFG_MAX_HEIGHT: max_height_r <= cfg_wdata;
        CFG_WEIGHTED:   weighted_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign occ       = {1'b0, fifo_cnt} + (FIFO_AW+2)'(inflight);
  assign credit_ok = occ < (FIFO_AW+2)'(FIFO_DEPTH);
  assign in_tready = credit_ok && !burst;
  assign in_fire   = in_tvalid && in_tready;

  bsg_parser #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .DIM_BITS     (DIM_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .in_start   (in_tuser),
    .credit_ok  (credit_ok),
    .max_width  (max_width_r),
    .max_height (max_height_r),
    .burst      (burst),
    .req_v      (req_v),
    .req        (req),
    .pal_wr     (pal_wr),
    .pal_rd_en  (pal_rd_en),
    .pal_rd_addr(pal_rd_addr)
  );

  bsg_palette_ram #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr     (pal_wr),
    .rd_en  (pal_rd_en),
    .rd_addr(pal_rd_addr),
    .rd_data(pal_q)
  );

  bsg_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .weighted (weighted_r),
    .req_v    (req_v),
    .req      (req),
    .pal_q    (pal_q),
    .inflight (inflight),
    .push     (push),
    .push_item(push_item)
  );

  assign pop = out_tvalid && out_tready;

  bsg_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .valid    (out_tvalid),
    .head     (head),
    .count    (fifo_cnt)
  );

  assign out_tdata = {5'd0, head.h, head.w, head.status, head.col, head.row, head.gray};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ===== tb/bsg_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bsg_stream_checker
// Watches the byte and result channels of bmp_stream_to_grayscale, decodes
// every accepted file byte with its own BMP parser and compares each result
// transaction field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module bsg_stream_checker
  import bsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          pending,
  output int          errors
);

  typedef enum logic [1:0] {PARSE_HDR, SKIP_PAL, DECODE_PIX, FILE_DONE} parse_t;

  out_item_t   expected_q[$];
  logic [15:0] lim_w, lim_h;
  logic        luma_on;
  parse_t      parse;
  logic [31:0] pos, asm_word, pix_offset, hdr_bytes, cols_total, rows_total;
  logic [31:0] bpp, colors, row_n, col_n, pad_n, chan_n, part;
  logic        top_down;
  logic [23:0] pal_mem[256];

  assign pending = expected_q.size();

  function automatic logic [7:0] luma(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    if (luma_on) return (r * 30 + g * 59 + b * 11) / 100;
    return (r + g + b) / 3;
  endfunction

  function automatic logic [7:0] pal_luma(logic [31:0] idx);
    logic [23:0] c;
    c = (idx < 256) ? pal_mem[idx[7:0]] : 24'd0;
    return luma(c[23:16], c[15:8], c[7:0]);
  endfunction

  function void push_status(logic [2:0] code, logic last);
    out_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.status = code;
    it.w = cols_total[15:0];
    it.h = rows_total[15:0];
    it.last = last;
    expected_q.push_back(it);
  endfunction

  function void abort_file(logic [2:0] code);
    push_status(code, 1'b1);
    parse = FILE_DONE;
  endfunction

  function void start_pixels();
    parse = DECODE_PIX;
    row_n = 0; col_n = 0; pad_n = 0; chan_n = 0; part = 0;
  endfunction

  function logic [31:0] row_padding();
    logic [31:0] rb;
    case (bpp)
      32: rb = cols_total * 4;
      24: rb = cols_total * 3;
      8: rb = cols_total;
      4: rb = (cols_total + 1) / 2;
      default: rb = (cols_total + 7) / 8;
    endcase
    return (4 - (rb & 3)) & 3;
  endfunction

  function void close_header(logic [31:0] clr, logic [31:0] p);
    logic    os2;
    longint  cnt, pal_end;
    os2 = (hdr_bytes == 12);
    if (os2 || clr == 0)
      cnt = (bpp == 8) ? 256 : (bpp == 4) ? 16 : (bpp == 1) ? 2 : 0;
    else
      cnt = clr;
    if (cnt > 256) cnt = 256;
    colors = cnt;
    pal_end = 14 + longint'(hdr_bytes) + cnt * (os2 ? 3 : 4);
    if (longint'(pix_offset) < pal_end) begin
      abort_file(ST_BAD_OFFSET);
    end else if (cols_total == 0 || rows_total == 0) begin
      abort_file(ST_OK);
    end else begin
      push_status(ST_OK, 1'b0);
      col_n = 0; chan_n = 0; part = 0;
      if (longint'(pix_offset) == longint'(p) + 1) start_pixels();
      else parse = SKIP_PAL;
    end
  endfunction

  function void header_byte(logic [7:0] b);
    logic [31:0] p, hi, mag;
    p = pos;
    asm_word = {b, asm_word[31:8]};
    hi = asm_word >> 16;
    pos = p + 1;
    if (p == 1 && hi != BMP_SIGNATURE) begin
      abort_file(ST_NOT_BMP);
      return;
    end
    if (p == 13) pix_offset = asm_word;
    if (p == 17) begin
      hdr_bytes = asm_word;
      if (asm_word < 40 && asm_word != 12) begin
        abort_file(ST_BAD_HDR);
        return;
      end
    end
    if (p <= 17) return;
    if (hdr_bytes == 12) begin
      if (p == 19) begin
        cols_total = hi;
        if (hi > lim_w) abort_file(ST_TOO_LARGE);
      end else if (p == 21) begin
        rows_total = hi;
        if (hi > lim_h) abort_file(ST_TOO_LARGE);
      end else if (p == 23 && hi != 1) begin
        abort_file(ST_UNSUPPORT);
      end else if (p == 25) begin
        if (!(hi == 1 || hi == 4 || hi == 8 || hi == 24 || hi == 32)) begin
          abort_file(ST_UNSUPPORT);
        end else begin
          bpp = hi;
          close_header(0, p);
        end
      end
    end else begin
      if (p == 21) begin
        cols_total = asm_word & 32'hFFFF;
        if (asm_word > lim_w) abort_file(ST_TOO_LARGE);
      end else if (p == 25) begin
        mag = asm_word;
        if (asm_word[31]) begin
          mag = -asm_word;
          top_down = 1'b1;
        end
        rows_total = mag & 32'hFFFF;
        if (mag > lim_h) abort_file(ST_TOO_LARGE);
      end else if (p == 27 && hi != 1) begin
        abort_file(ST_UNSUPPORT);
      end else if (p == 29) begin
        if (!(hi == 1 || hi == 4 || hi == 8 || hi == 24 || hi == 32)) abort_file(ST_UNSUPPORT);
        else bpp = hi;
      end else if (p == 49) begin
        close_header(asm_word, p);
      end
    end
  endfunction

  function void palette_byte(logic [7:0] b);
    logic [31:0] p;
    p = pos;
    if (longint'(p) >= 14 + longint'(hdr_bytes) && col_n < colors) begin
      case (chan_n & 3)
        0: begin part = b; chan_n = 1; end
        1: begin part = part | (b << 8); chan_n = 2; end
        2: begin
          if (col_n < 256) pal_mem[col_n[7:0]] = {b, part[15:0]};
          if (hdr_bytes == 12) begin
            col_n++;
            chan_n = 0;
          end else begin
            chan_n = 3;
          end
        end
        default: begin col_n++; chan_n = 0; end
      endcase
    end
    pos = p + 1;
    if (p + 1 == pix_offset) start_pixels();
  endfunction

  function bit emit_pixel(logic [7:0] level);
    out_item_t it;
    bit        ended;
    it = '0;
    it.gray = level;
    it.row = top_down ? row_n[15:0] : rows_total[15:0] - 16'd1 - row_n[15:0];
    it.col = col_n[15:0];
    ended = 0;
    col_n++;
    if (col_n >= cols_total) begin
      ended = 1;
      col_n = 0;
      row_n++;
      if (row_n >= rows_total) begin
        it.last = 1'b1;
        parse = FILE_DONE;
      end else begin
        pad_n = row_padding();
      end
    end
    expected_q.push_back(it);
    return ended;
  endfunction

  function void pixel_byte(logic [7:0] b);
    if (pad_n != 0) begin
      pad_n--;
      return;
    end
    case (bpp)
      32, 24: begin
        if (chan_n == 0) begin
          part = b;
          chan_n = 1;
        end else if (chan_n == 1) begin
          part = part | (b << 8);
          chan_n = 2;
        end else if (chan_n == 2) begin
          if (bpp == 24) begin
            chan_n = 0;
            void'(emit_pixel(luma(b, part[15:8], part[7:0])));
          end else begin
            part = luma(b, part[15:8], part[7:0]);
            chan_n = 3;
          end
        end else begin
          chan_n = 0;
          void'(emit_pixel(part[7:0]));
        end
      end
      8: void'(emit_pixel(pal_luma(b)));
      4: begin
        if (!emit_pixel(pal_luma(b[7:4]))) void'(emit_pixel(pal_luma(b[3:0])));
      end
      default: begin
        for (int k = 7; k >= 0; k--)
          if (emit_pixel(pal_luma(b[k]))) break;
      end
    endcase
  endfunction

  function void clear_parser();
    parse = PARSE_HDR;
    pos = 0; asm_word = 0; pix_offset = 0; hdr_bytes = 0;
    cols_total = 0; rows_total = 0; top_down = 0; bpp = 0; colors = 0;
    row_n = 0; col_n = 0; pad_n = 0; chan_n = 0; part = 0;
  endfunction

  function void file_byte(logic [7:0] b, logic first);
    if (first) clear_parser();
    case (parse)
      PARSE_HDR: header_byte(b);
      SKIP_PAL: palette_byte(b);
      DECODE_PIX: pixel_byte(b);
      default: ;
    endcase
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lim_w = 16'hFFFF;
      lim_h = 16'hFFFF;
      luma_on = 1'b0;
      clear_parser();
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX_WIDTH: lim_w = cfg_wdata;
          CFG_MAX_HEIGHT: lim_h = cfg_wdata;
          CFG_WEIGHTED: luma_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) file_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction tdata=%h tuser=%b", out_tdata, out_tuser);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, out_tuser); errors++;
          end
          if (out_tdata[7:0] !== want.gray) begin
            $error("gray: expected %0d actual %0d", want.gray, out_tdata[7:0]); errors++;
          end
          if (out_tdata[23:8] !== want.row) begin
            $error("row: expected %0d actual %0d", want.row, out_tdata[23:8]); errors++;
          end
          if (out_tdata[39:24] !== want.col) begin
            $error("column: expected %0d actual %0d", want.col, out_tdata[39:24]); errors++;
          end
          if (out_tdata[42:40] !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_tdata[42:40]);
            errors++;
          end
          if (out_tdata[58:43] !== want.w) begin
            $error("image_width: expected %0d actual %0d", want.w, out_tdata[58:43]);
            errors++;
          end
          if (out_tdata[74:59] !== want.h) begin
            $error("image_height: expected %0d actual %0d", want.h, out_tdata[74:59]);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, out_tlast); errors++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_bmp_stream_to_grayscale.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp_stream_to_grayscale
// Streams short directed BMP files, including malformed and truncated ones,
// into the block, first under random source gaps and sink stalls; the checker
// predicts every status and pixel result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_bmp_stream_to_grayscale
  import bsg_pkg::*;
();

  localparam int CYCLE_LIMIT = 50000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready, out_tuser, out_tlast;
  logic [79:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  int          pending, errors, cycles, hold_left, stall_left;
  bit          gaps_on;
  logic [7:0]  file_q[$];

  bmp_stream_to_grayscale dut (.*);

  bsg_stream_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic add8(logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic add16(logic [15:0] v);
    add8(v[7:0]); add8(v[15:8]);
  endtask

  task automatic add32(logic [31:0] v);
    add16(v[15:0]); add16(v[31:16]);
  endtask

  task automatic add_random(int n);
    repeat (n) add8(8'($urandom));
  endtask

  // keep palette indices inside the entries this file loads
  function automatic logic [7:0] pix_byte(int bpp, int cnt);
    logic [7:0] b;
    int         lim;
    b = 8'($urandom);
    lim = (cnt < 16) ? cnt : 16;
    if (bpp == 8) begin
      b = 8'($urandom_range(0, cnt - 1));
    end else if (bpp == 4) begin
      b = {4'($urandom_range(0, lim - 1)), 4'($urandom_range(0, lim - 1))};
    end else if (bpp == 1 && cnt < 2) begin
      b = 8'd0;
    end
    return b;
  endfunction

  task automatic build_file(bit os2, int bpp, int w, int h, int clr, int hsz, int gap,
                            int planes);
    int cnt, esz, rows, rb;
    file_q.delete();
    if (os2) hsz = 12;
    if (os2 || clr == 0) cnt = (bpp == 8) ? 256 : (bpp == 4) ? 16 : (bpp == 1) ? 2 : 0;
    else cnt = clr;
    if (cnt > 256) cnt = 256;
    esz = os2 ? 3 : 4;
    add16(BMP_SIGNATURE);
    add32($urandom);
    add32(0);
    add32(14 + hsz + cnt * esz + gap);
    add32(hsz);
    if (os2) begin
      add16(w); add16(h); add16(planes); add16(bpp);
    end else begin
      add32(w); add32(h); add16(planes); add16(bpp);
      add_random(16);
      add32(clr);
      add32(0);
      add_random(hsz - 40);
    end
    add_random(cnt * esz + (gap > 0 ? gap : 0));
    rows = (h < 0) ? -h : h;
    if (w <= 0) rows = 0;
    case (bpp)
      32: rb = w * 4;
      24: rb = w * 3;
      8: rb = w;
      4: rb = (w + 1) / 2;
      1: rb = (w + 7) / 8;
      default: rb = w * 2;
    endcase
    repeat (rows) begin
      repeat (rb) add8(pix_byte(bpp, cnt));
      add_random((4 - (rb & 3)) & 3);
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic first);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tuser = first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_file(int upto);
    for (int i = 0; i < file_q.size() && i < upto; i++) send_byte(file_q[i], i == 0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(logic [15:0] mw, logic [15:0] mh, logic wl);
    drain();
    write_reg(CFG_MAX_WIDTH, mw);
    write_reg(CFG_MAX_HEIGHT, mh);
    write_reg(CFG_WEIGHTED, {15'd0, wl});
  endtask

  task automatic run_file(bit os2, int bpp, int w, int h, int clr, int hsz, int gap);
    build_file(os2, bpp, w, h, clr, hsz, gap, 1);
    send_file(file_q.size());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    cycles = 0; hold_left = 0; stall_left = 0; gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_limits(16'hFFFF, 16'hFFFF, 1'b0);
    // hold the sink while a 1 bit file bursts pixels into the queue
    hold_left = 60;
    run_file(1, 1, 9, 2, 0, 12, 0);
    run_file(0, 4, 3, -1, 3, 40, 1);
    run_file(1, 32, 1, 2, 0, 12, 0);
    build_file(1, 24, 2, 2, 0, 12, 0, 1);
    file_q[1] = 8'h4E;
    send_file(4);
    build_file(0, 24, 2, 2, 0, 20, 0, 1);
    send_file(18);
    build_file(1, 24, 2, 2, 0, 12, 0, 2);
    send_file(24);
    build_file(1, 1, 2, 2, 0, 12, -1, 1);
    send_file(26);
    run_file(1, 24, 0, 2, 0, 12, 0);

    set_limits(16'd7, 16'd3, 1'b1);
    gaps_on = 1'b0;
    build_file(1, 24, 3, 4, 0, 12, 0, 1);
    send_file(22);
    run_file(1, 24, 2, 1, 0, 12, 0);
    run_file(0, 8, 2, 1, 2, 40, 0);

    @(negedge clk);
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
